// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the transcoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/u8u16_pkg.sv =====
package u8u16_pkg;

	// UTF-16 surrogate bases and supplementary plane offset
	localparam logic [15:0] SUR_HI_BASE = 16'hD800;
	localparam logic [15:0] SUR_LO_BASE = 16'hDC00;
	localparam logic [20:0] SUPP_BASE   = 21'h10000;

	// Results produced by one byte, handed from decoder to output buffer
	typedef struct packed {
		logic [1:0]  n;      // number of units: 0, 1 or 2
		logic [15:0] unit0;
		logic        last0;
		logic [15:0] unit1;
		logic        last1;
	} u8u16_res_t;

endpackage

// ===== hw/rtl/u8u16_decode.sv =====
`include "assert_macros.svh"

module u8u16_decode import u8u16_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,
	input  logic [1:0] space,     // free result slots this cycle
	output logic       push,
	output u8u16_res_t res
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic [1:0]  pend_q;
	logic [20:0] acc_q;

	logic [20:0] start_acc;
	logic [1:0]  start_pend;
	logic        pass;
	logic        hold;
	logic [20:0] cp;
	logic [20:0] v;
	logic [1:0]  pend_nx;
	logic [20:0] acc_nx;

	// Item leaves the input register once its results fit downstream
	assign push     = valid_s1 && (res.n <= space);
	assign s_tready = !valid_s1 || push;

	// Input register: valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input register: payload
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
			acc_q  <= '0;
		end else if (push) begin
			pend_q <= pend_nx;
			acc_q  <= acc_nx;
		end
	end

	// Byte classification, accumulation and unit formation
	always_comb begin
		start_acc  = '0;
		start_pend = 2'd0;
		pass       = 1'b0;
		if (pend_q != 2'd0) begin
			start_acc  = {acc_q[14:0], byte_s1[5:0]};
			start_pend = pend_q - 2'd1;
		end else if (byte_s1[7:5] == 3'b110) begin
			start_acc  = {16'd0, byte_s1[4:0]};
			start_pend = 2'd1;
		end else if (byte_s1[7:4] == 4'b1110) begin
			start_acc  = {17'd0, byte_s1[3:0]};
			start_pend = 2'd2;
		end else if (byte_s1[7:3] == 5'b11110) begin
			start_acc  = {18'd0, byte_s1[2:0]};
			start_pend = 2'd3;
		end else begin
			pass = 1'b1;
		end

		hold = !pass && (start_pend != 2'd0) && !last_s1;

		// a cut-short sequence gets zero bits for missing continuations
		case (start_pend)
			2'd0:    cp = start_acc;
			2'd1:    cp = {start_acc[14:0], 6'd0};
			2'd2:    cp = {start_acc[8:0], 12'd0};
			default: cp = {start_acc[2:0], 18'd0};
		endcase
		if (pass) begin
			cp = {13'd0, byte_s1};
		end

		if (hold) begin
			pend_nx = start_pend;
			acc_nx  = start_acc;
		end else begin
			pend_nx = 2'd0;
			acc_nx  = '0;
		end

		v = cp - SUPP_BASE;
		res.unit1 = SUR_LO_BASE | {6'd0, v[9:0]};
		res.last1 = last_s1;
		if (hold) begin
			res.n     = 2'd0;
			res.unit0 = cp[15:0];
			res.last0 = 1'b0;
		end else if (cp[20:16] != 5'd0) begin
			res.n     = 2'd2;
			res.unit0 = SUR_HI_BASE | {6'd0, v[19:10]};
			res.last0 = 1'b0;
		end else begin
			res.n     = 2'd1;
			res.unit0 = cp[15:0];
			res.last0 = last_s1;
		end
	end

	`ASSERT_AT(a_idle_acc_clear, clk, arst_n, (pend_q == 2'd0) |-> (acc_q == 21'd0),
		"accumulator not clear while no sequence is open")
	`ASSERT_AT(a_acc_narrow, clk, arst_n, (pend_q != 2'd0) |-> (acc_q[20:15] == 6'd0),
		"open sequence holds more bits than possible")
	`ASSERT_AT(a_pair_last, clk, arst_n, (res.n == 2'd2) |-> !res.last0,
		"high surrogate marked as last unit")

endmodule

// ===== hw/rtl/u8u16_outbuf.sv =====
`include "assert_macros.svh"

module u8u16_outbuf import u8u16_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  u8u16_res_t  res,
	output logic [1:0]  space,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [15:0] unit
	output logic        m_tlast
);

	logic [1:0]  cnt_q;
	logic [15:0] u0_q;
	logic [15:0] u1_q;
	logic        l0_q;
	logic        l1_q;

	logic        pop;
	logic [1:0]  base;
	logic [1:0]  n_in;
	logic [15:0] u0_nx;
	logic [15:0] u1_nx;
	logic        l0_nx;
	logic        l1_nx;

	assign m_tvalid = cnt_q != 2'd0;
	assign m_tdata  = u0_q;
	assign m_tlast  = l0_q;
	assign pop      = m_tvalid && m_tready;
	assign base     = cnt_q - {1'b0, pop};
	assign space    = 2'd2 - base;
	assign n_in     = push ? res.n : 2'd0;

	// Two-slot queue: shift out the head, append new units behind what remains
	always_comb begin
		case (base)
			2'd0: begin
				u0_nx = res.unit0;
				l0_nx = res.last0;
				u1_nx = res.unit1;
				l1_nx = res.last1;
			end
			2'd1: begin
				u0_nx = pop ? u1_q : u0_q;
				l0_nx = pop ? l1_q : l0_q;
				u1_nx = res.unit0;
				l1_nx = res.last0;
			end
			default: begin
				u0_nx = u0_q;
				l0_nx = l0_q;
				u1_nx = u1_q;
				l1_nx = l1_q;
			end
		endcase
	end

	// Fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= base + n_in;
		end
	end

	// Slot payload
	always_ff @(posedge clk) begin
		u0_q <= u0_nx;
		l0_q <= l0_nx;
		u1_q <= u1_nx;
		l1_q <= l1_nx;
	end

	`ASSERT_NEVER(a_no_overflow, clk, arst_n, push && (res.n > space),
		"result pushed without room")
	`ASSERT_NEVER(a_cnt_range, clk, arst_n, cnt_q == 2'd3, "fill count out of range")
	`ASSERT_AT(a_full_hold, clk, arst_n,
		(cnt_q == 2'd2 && !m_tready) |=> (cnt_q == 2'd2 && $stable(u0_q)),
		"full buffer changed while stalled")

endmodule

// ===== hw/rtl/utf8_to_utf16_transcoder.sv =====
// UTF-8 to UTF-16 stream transcoder. Takes one UTF-8 byte per item on the
// s_ side and emits UTF-16 code units on the m_ side; tlast on the final byte
// of a string is carried to the final unit, and a sequence cut short by tlast
// is completed with zero bits. Bytes are accepted at one per cycle while the
// input is not stalled, passing through an input register, then a two-slot
// result buffer. A 4-byte sequence that ends in a surrogate pair delivers
// two units one after the other through the single output port; the input
// stalls while the units of the held byte do not fit in the result slots
// left free after this cycle's output.

module utf8_to_utf16_transcoder import u8u16_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // in_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] unit
	output logic        m_tlast    // out_last
);

	u8u16_res_t res;
	logic       push;
	logic [1:0] space;

	u8u16_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.space    (space),
		.push     (push),
		.res      (res)
	);

	u8u16_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.res      (res),
		.space    (space),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
